@@ rtl/core/lnsa_pkg.sv @@
// ----------------------------------------------------------------------------
// lnsa_pkg
// Shared types and constants for the natural logarithm core: fixed-point
// formats, the reciprocal table for the series divisors and the sideband
// record that travels along the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lnsa_pkg;

   // Fraction bits of z, of the powers of z and of the series sum.
   localparam int ZF = 30;

   // Default result format and series length.
   localparam int FRAC_BITS_DEF    = 24;
   localparam int SERIES_TERMS_DEF = 5;
   localparam int MAX_TERMS        = 8;

   // Normalised mantissa width (hidden bit included) and exponent width.
   localparam int MW = 24;
   localparam int KW = 9;

   // Divider: partial remainder width and quotient bits per stage.
   localparam int RW             = 25;
   localparam int DIV_BITS_STAGE = 2;
   localparam int DIV_STAGES     = ZF / DIV_BITS_STAGE;

   // Reciprocal multipliers for floor(p / (2i+1)) with p below 2^29.
   localparam int RECIP_W = 31;
   localparam int PROD_W  = ZF + RECIP_W;
   localparam int SUM_W   = 31;

   localparam logic [RECIP_W-1:0] RECIP [MAX_TERMS] = '{
      31'd536870912, 31'd715827883, 31'd858993460, 31'd613566757,
      31'd954437177, 31'd780903145, 31'd660764200, 31'd572662307
   };
   localparam int RECIP_SHIFT [MAX_TERMS] = '{29, 31, 32, 32, 33, 33, 33, 33};

   // ln 2 with ZF fraction bits.
   localparam logic signed [31:0] LN2_Q = 32'sd744261118;

   // Sideband that runs alongside the data in every stage.
   typedef struct packed {
      logic          valid;
      logic          err;
      logic [KW-1:0] k;
   } side_type;

endpackage

`default_nettype wire

@@ rtl/core/lnsa_unpack.sv @@
// ----------------------------------------------------------------------------
// lnsa_unpack
// Two-stage operand decode: classifies the operand, counts the leading zeros
// of a subnormal fraction, then normalises the mantissa and forms exponent k.
// ----------------------------------------------------------------------------
`default_nettype none

module lnsa_unpack
   import lnsa_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire logic          in_valid,
   input  wire logic [31:0]   value_bits,
   output side_type           side_out,
   output logic [MW-1:0]      mant_out
);

   logic        v1_ff;
   logic        err1_ff;
   logic [7:0]  e1_ff;
   logic [22:0] f1_ff;
   logic [4:0]  lz1_ff;
   logic [4:0]  lz_in;
   logic        err_in;
   side_type    side2_ff;
   logic [MW-1:0] mant2_ff;
   logic [KW-1:0] k_in;
   logic [MW-1:0] mant_in;

   // Leading-zero count of the 23-bit fraction.
   always_comb begin
      lz_in = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (value_bits[i]) begin
            lz_in = 5'(22 - i);
         end
      end
   end

   // Zero, negative, infinity and NaN are outside the domain.
   assign err_in = (value_bits[30:23] == 8'hFF) || value_bits[31] ||
                   ((value_bits[30:23] == 8'h00) && (value_bits[22:0] == 23'd0));

   // First stage: classification and leading-zero count.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         err1_ff <= err_in;
         e1_ff   <= value_bits[30:23];
         f1_ff   <= value_bits[22:0];
         lz1_ff  <= lz_in;
      end
   end

   // Normalisation: a subnormal needs lz+1 shifts to reach the hidden bit.
   always_comb begin
      if (e1_ff != 8'd0) begin
         mant_in = {1'b1, f1_ff};
         k_in    = {1'b0, e1_ff} - 9'd127;
      end else begin
         mant_in = {f1_ff, 1'b0} << lz1_ff;
         k_in    = 9'd0 - 9'd127 - {4'd0, lz1_ff};
      end
   end

   // Second stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         side2_ff <= '0;
      end else if (advance) begin
         side2_ff.valid <= v1_ff;
         side2_ff.err   <= err1_ff;
         side2_ff.k     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mant2_ff <= mant_in;
      end
   end

   assign side_out = side2_ff;
   assign mant_out = mant2_ff;

endmodule

`default_nettype wire

@@ rtl/core/lnsa_divider.sv @@
// ----------------------------------------------------------------------------
// lnsa_divider
// Pipelined restoring divider for z = (m-1)/(m+1) with ZF fraction bits.
// Each stage resolves two quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none

module lnsa_divider
   import lnsa_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire side_type      side_in,
   input  wire logic [MW-1:0] mant_in,
   output side_type           side_out,
   output logic [ZF-1:0]      quot_out
);

   side_type      side_ff [DIV_STAGES];
   logic [RW-1:0] rem_ff  [DIV_STAGES];
   logic [RW-1:0] den_ff  [DIV_STAGES];
   logic [ZF-1:0] quo_ff  [DIV_STAGES];

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
      side_type      src_side;
      logic [RW-1:0] src_rem;
      logic [RW-1:0] src_den;
      logic [ZF-1:0] src_quo;
      logic [RW:0]   try_a;
      logic [RW:0]   try_b;
      logic          bit_a;
      logic          bit_b;
      logic [RW-1:0] rem_a;
      logic [RW-1:0] rem_in;

      // Stage source: the first stage sets remainder m-1 and divisor m+1.
      if (j == 0) begin : g_first
         assign src_side = side_in;
         assign src_rem  = {2'b00, mant_in[MW-2:0]};
         assign src_den  = {2'b10, mant_in[MW-2:0]};
         assign src_quo  = '0;
      end else begin : g_next
         assign src_side = side_ff[j-1];
         assign src_rem  = rem_ff[j-1];
         assign src_den  = den_ff[j-1];
         assign src_quo  = quo_ff[j-1];
      end

      // Two shift-compare-subtract steps.
      always_comb begin
         try_a  = {src_rem, 1'b0};
         bit_a  = (try_a >= {1'b0, src_den});
         rem_a  = bit_a ? RW'(try_a - {1'b0, src_den}) : try_a[RW-1:0];
         try_b  = {rem_a, 1'b0};
         bit_b  = (try_b >= {1'b0, src_den});
         rem_in = bit_b ? RW'(try_b - {1'b0, src_den}) : try_b[RW-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[j] <= '0;
         end else if (advance) begin
            side_ff[j] <= src_side;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j] <= rem_in;
            den_ff[j] <= src_den;
            quo_ff[j] <= {src_quo[ZF-3:0], bit_a, bit_b};
         end
      end
   end

   assign side_out = side_ff[DIV_STAGES-1];
   assign quot_out = quo_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

@@ rtl/core/lnsa_series.sv @@
// ----------------------------------------------------------------------------
// lnsa_series
// Odd power series z + z^3/3 + z^5/5 + ... One stage squares z, then one
// stage per term forms the reciprocal product of the current power and
// (but in the last) the next power; a closing stage adds the last term.
// ----------------------------------------------------------------------------
`default_nettype none

module lnsa_series
   import lnsa_pkg::*;
#(
   parameter int SERIES_TERMS = SERIES_TERMS_DEF
)(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire side_type      side_in,
   input  wire logic [ZF-1:0] z_in,
   output side_type           side_out,
   output logic [SUM_W-1:0]   sum_out
);

   localparam int T = SERIES_TERMS;

   side_type          side_ff [T+1];
   logic [ZF-1:0]     p_ff    [T];
   logic [ZF-1:0]     z2_ff   [T];
   logic [PROD_W-1:0] prod_ff [T];
   logic [SUM_W-1:0]  sum_ff  [T];
   side_type          side_fin_ff;
   logic [SUM_W-1:0]  sum_fin_ff;
   logic [2*ZF-1:0]   sq_full;

   // Squaring stage.
   assign sq_full = z_in * z_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff[0] <= '0;
      end else if (advance) begin
         side_ff[0] <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff[0]  <= z_in;
         z2_ff[0] <= sq_full[2*ZF-1:ZF];
      end
   end

   // One stage per term.
   for (genvar t = 0; t < T; t++) begin : g_term
      logic [SUM_W-1:0] sum_in;

      if (t == 0) begin : g_first
         assign sum_in = '0;
      end else begin : g_acc
         assign sum_in = sum_ff[t-1] + SUM_W'(prod_ff[t-1] >> RECIP_SHIFT[t-1]);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[t+1] <= '0;
         end else if (advance) begin
            side_ff[t+1] <= side_ff[t];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            prod_ff[t] <= p_ff[t] * RECIP[t];
            sum_ff[t]  <= sum_in;
         end
      end

      // The next odd power is needed by every term but the last.
      if (t < T - 1) begin : g_pow
         logic [2*ZF-1:0] pw_full;

         assign pw_full = p_ff[t] * z2_ff[t];

         always_ff @(posedge clock) begin
            if (advance) begin
               p_ff[t+1]  <= pw_full[2*ZF-1:ZF];
               z2_ff[t+1] <= z2_ff[t];
            end
         end
      end
   end

   // Closing stage adds the last term.
   always_ff @(posedge clock) begin
      if (reset) begin
         side_fin_ff <= '0;
      end else if (advance) begin
         side_fin_ff <= side_ff[T];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_fin_ff <= sum_ff[T-1] + SUM_W'(prod_ff[T-1] >> RECIP_SHIFT[T-1]);
      end
   end

   assign side_out = side_fin_ff;
   assign sum_out  = sum_fin_ff;

endmodule

`default_nettype wire

@@ rtl/core/natural_log_series_approx_core.sv @@
// ----------------------------------------------------------------------------
// natural_log_series_approx_core
// Natural logarithm of an IEEE-754 single-precision operand, returned as
// signed fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// The core takes one operand every clock cycle while it is not held and
// returns one result per operand, in order, through two decode stages,
// fifteen divider stages at two quotient bits each, SERIES_TERMS + 2 series
// stages and two output stages. The whole pipeline holds when a finished
// result is not taken, so req_ready is low only while rsp_valid is high and
// rsp_ready is low. Zero, negative, infinite and NaN operands give
// rsp_domain_error with a value of 0.
`default_nettype none

module natural_log_series_approx_core
   import lnsa_pkg::*;
#(
   parameter int FRAC_BITS    = FRAC_BITS_DEF,
   parameter int SERIES_TERMS = SERIES_TERMS_DEF
)(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [31:0]        req_value_bits,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_log_value,
   output logic                    rsp_domain_error
);

   localparam int TW    = KW + 32;
   localparam int PADW  = TW - SUM_W - 1;
   localparam int SHIFT = ZF - FRAC_BITS;
   localparam logic signed [TW-1:0] HALF = TW'(1) << (SHIFT - 1);

   logic              advance;
   side_type          unp_side;
   logic [MW-1:0]     unp_mant;
   side_type          div_side;
   logic [ZF-1:0]     div_quot;
   side_type          ser_side;
   logic [SUM_W-1:0]  ser_sum;
   side_type          fin_side_ff;
   logic [SUM_W-1:0]  fin_sum_ff;
   logic signed [TW-1:0] kl_in;
   logic signed [TW-1:0] kl_ff;
   logic signed [TW-1:0] total;
   logic signed [TW-1:0] rounded;
   logic              rsp_valid_ff;
   logic              rsp_err_ff;
   logic signed [31:0] rsp_log_ff;

   // The pipeline moves whenever the output register is free or being read.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   lnsa_unpack u_unpack (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_valid),
      .value_bits (req_value_bits),
      .side_out   (unp_side),
      .mant_out   (unp_mant)
   );

   lnsa_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .side_in  (unp_side),
      .mant_in  (unp_mant),
      .side_out (div_side),
      .quot_out (div_quot)
   );

   lnsa_series #(
      .SERIES_TERMS (SERIES_TERMS)
   ) u_series (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .side_in  (div_side),
      .z_in     (div_quot),
      .side_out (ser_side),
      .sum_out  (ser_sum)
   );

   // Exponent contribution k * ln2.
   assign kl_in = $signed(ser_side.k) * LN2_Q;

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_side_ff <= '0;
      end else if (advance) begin
         fin_side_ff <= ser_side;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kl_ff      <= kl_in;
         fin_sum_ff <= ser_sum;
      end
   end

   // Total of 2*sum + k*ln2, rounded half up to FRAC_BITS fraction bits.
   assign total   = kl_ff + $signed({{PADW{1'b0}}, fin_sum_ff, 1'b0}) + HALF;
   assign rounded = total >>> SHIFT;

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= fin_side_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_err_ff <= fin_side_ff.err;
         rsp_log_ff <= fin_side_ff.err ? 32'sd0 : $signed(rounded[31:0]);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_domain_error = rsp_err_ff;
   assign rsp_log_value    = rsp_log_ff;

endmodule

`default_nettype wire

@@ rtl/core/lnsa_checker.sv @@
// ----------------------------------------------------------------------------
// lnsa_checker
// Port-level checks for the natural logarithm core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lnsa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_log_value,
   input wire logic        rsp_domain_error
);

   // A result held back stays offered.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

   // A result held back keeps its payload.
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_log_value) && $stable(rsp_domain_error))
      else $error("result payload changed while stalled");

   // An empty output stage never blocks new operands.
   a_ready_free : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // A domain error always carries a zero value.
   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_domain_error |-> rsp_log_value == 32'd0)
      else $error("domain error with nonzero value");

   // Nothing is offered straight after reset.
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind natural_log_series_approx_core lnsa_checker u_lnsa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_log_value    (rsp_log_value),
   .rsp_domain_error (rsp_domain_error)
);

`default_nettype wire

@@ tb/natural_log_series_approx_core_tb.sv @@
// ----------------------------------------------------------------------------
// natural_log_series_approx_core_tb
// Self-checking bench for the natural logarithm core. A table of directed
// operands (special values, extremes, subnormals) is followed by random
// operands; every result is compared in order with a known value or a
// bit-exact model of the fixed-point series; both sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module natural_log_series_approx_core_tb;
   import lnsa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM    = 430;
   localparam int PIPE_CYCLES = 21 + SERIES_TERMS_DEF;
   localparam int ZF_BITS     = 30;
   localparam int RES_FRAC    = FRAC_BITS_DEF;

   typedef struct {
      logic signed [31:0] log_value;
      logic               domain_error;
   } ln_result_type;

   typedef struct {
      logic [31:0]   bits;
      logic          known;
      ln_result_type res;
   } ln_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [31:0]       req_value_bits = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic signed [31:0] rsp_log_value;
   logic              rsp_domain_error;

   ln_result_type     pending_logs[$];
   int                fail_count = 0;
   int                checked_count = 0;
   int                error_count = 0;
   bit                sending_done = 1'b0;
   bit                long_hold = 1'b0;

   natural_log_series_approx_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value_bits   (req_value_bits),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_log_value    (rsp_log_value),
      .rsp_domain_error (rsp_domain_error)
   );

   // Clock generation.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bit-exact prediction of the logarithm in fixed point.
   function automatic ln_result_type predict_log(logic [31:0] bits);
      ln_result_type    r;
      logic [7:0]       ex;
      logic [22:0]      fr;
      logic [63:0]      mant, z, z2, p, s, one;
      longint           k, total;
      logic [63:0]      biased, rounded;
      r.log_value    = '0;
      r.domain_error = 1'b1;
      ex = bits[30:23];
      fr = bits[22:0];
      if (ex == 8'hFF || (ex == 8'h00 && fr == '0) || bits[31])
         return r;
      if (ex != 8'h00) begin
         mant = {40'd0, 1'b1, fr};
         k    = longint'(ex) - 127;
      end else begin
         mant = {41'd0, fr};
         k    = -126;
         while (mant[23] == 1'b0) begin
            mant = mant << 1;
            k--;
         end
      end
      one = 64'd1 << 23;
      z   = ((mant - one) << ZF_BITS) / (mant + one);
      z2  = (z * z) >> ZF_BITS;
      p   = z;
      s   = '0;
      for (int i = 0; i < SERIES_TERMS_DEF; i++) begin
         s = s + p / 64'(2 * i + 1);
         p = (p * z2) >> ZF_BITS;
      end
      total   = longint'(2 * s) + k * 744261118;
      biased  = 64'(total) + (64'd128 << ZF_BITS);
      rounded = (biased + (64'd1 << (ZF_BITS - RES_FRAC - 1))) >> (ZF_BITS - RES_FRAC);
      r.log_value    = 32'(longint'(rounded) - (longint'(128) << RES_FRAC));
      r.domain_error = 1'b0;
      return r;
   endfunction

   // Offers one operand after a random gap and waits for its transfer.
   // Entered and left at a falling edge; valid stays high between
   // operands sent back to back.
   task automatic send_operand(logic [31:0] bits, ln_result_type exp_res);
      int gap;
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_value_bits <= bits;
      do @(posedge clock); while (!req_ready);
      pending_logs.push_back(exp_res);
      if (exp_res.domain_error) error_count++;
      @(negedge clock);
   endtask

   // Random operand: mostly positive normals of every exponent, with
   // subnormals, specials and negatives mixed in.
   function automatic logic [31:0] random_operand();
      int sel;
      logic [31:0] v;
      sel = $urandom_range(0, 19);
      v   = $urandom;
      if (sel < 12) begin
         v[31] = 1'b0;
         if (v[30:23] == 8'hFF) v[30:23] = 8'hFE;
         if (v[30:23] == 8'h00) v[30:23] = 8'h01;
      end else if (sel < 14) begin
         v[31] = 1'b0;
         v[30:23] = 8'd127;
      end else if (sel < 16) begin
         v[31:23] = '0;
         v[22:0]  = v[22:0] >> $urandom_range(0, 22);
         if (v[22:0] == '0) v[0] = 1'b1;
      end else if (sel < 18) begin
         v[31] = 1'b1;
      end else begin
         v[30:23] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      end
      return v;
   endfunction

   // Stimulus: directed table, then random operands.
   initial begin
      ln_row_type table_rows[$];
      ln_result_type err_res, zero_res;
      logic [31:0] v;
      err_res.log_value  = '0; err_res.domain_error  = 1'b1;
      zero_res.log_value = '0; zero_res.domain_error = 1'b0;
      table_rows = '{
         '{32'h3F80_0000, 1'b1, zero_res},        // exactly one
         '{32'h0000_0000, 1'b1, err_res},         // positive zero
         '{32'h8000_0000, 1'b1, err_res},         // negative zero
         '{32'hBF80_0000, 1'b1, err_res},         // negative one
         '{32'hFFFF_FFFF, 1'b1, err_res},         // negative NaN
         '{32'h7F80_0000, 1'b1, err_res},         // positive infinity
         '{32'hFF80_0000, 1'b1, err_res},         // negative infinity
         '{32'h7FC0_0000, 1'b1, err_res},         // quiet NaN
         '{32'h7F80_0001, 1'b1, err_res},         // signalling NaN
         '{32'h8000_0001, 1'b1, err_res},         // negative subnormal
         '{32'h0000_0001, 1'b0, zero_res},        // smallest subnormal
         '{32'h007F_FFFF, 1'b0, zero_res},        // largest subnormal
         '{32'h0040_0000, 1'b0, zero_res},
         '{32'h0080_0000, 1'b0, zero_res},        // smallest normal
         '{32'h7F7F_FFFF, 1'b0, zero_res},        // largest normal
         '{32'h3FFF_FFFF, 1'b0, zero_res},        // mantissa just below two
         '{32'h3F80_0001, 1'b0, zero_res},        // just above one
         '{32'h3F7F_FFFF, 1'b0, zero_res},        // just below one
         '{32'h4000_0000, 1'b0, zero_res},        // two
         '{32'h402D_F854, 1'b0, zero_res},        // about e
         '{32'h3F00_0000, 1'b0, zero_res},        // one half
         '{32'h5555_5555, 1'b0, zero_res},
         '{32'h2AAA_AAAA, 1'b0, zero_res}
      };
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (table_rows[i])
         send_operand(table_rows[i].bits,
                      table_rows[i].known ? table_rows[i].res
                                          : predict_log(table_rows[i].bits));
      for (int n = 0; n < N_RANDOM; n++) begin
         v = random_operand();
         send_operand(v, predict_log(v));
      end
      req_valid <= 1'b0;
      sending_done = 1'b1;
   end

   // Receiver: random stalls, plus one long hold-off to fill the pipeline.
   initial begin
      int wait_cycles;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!long_hold && checked_count == 150) begin
            long_hold = 1'b1;
            rsp_ready <= 1'b0;
            repeat (3 * PIPE_CYCLES) @(negedge clock);
         end
         wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
         if (checked_count > 300 && checked_count < 360) wait_cycles = 0;
         if (wait_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Result checking at the rising edge.
   always @(posedge clock) begin
      ln_result_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_logs.size() == 0) begin
            $error("result with nothing expected: log_value %0d", rsp_log_value);
            fail_count++;
         end else begin
            exp_res = pending_logs.pop_front();
            if (rsp_log_value !== exp_res.log_value) begin
               $error("log_value: expected %0d, got %0d", exp_res.log_value,
                      rsp_log_value);
               fail_count++;
            end
            if (rsp_domain_error !== exp_res.domain_error) begin
               $error("domain_error: expected %0b, got %0b",
                      exp_res.domain_error, rsp_domain_error);
               fail_count++;
            end
         end
         checked_count++;
      end
   end

   // End of run: drain, settle, then report.
   initial begin
      wait (sending_done);
      while (pending_logs.size() != 0) @(posedge clock);
      repeat (2 * PIPE_CYCLES) @(posedge clock);
      if (pending_logs.size() != 0) fail_count++;
      $display("Checked %0d logarithm results, %0d of them domain errors,",
               checked_count, error_count);
      $display("with random stalls on both sides and one long output hold.");
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #2ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/lnsa_pkg.sv
rtl/core/lnsa_unpack.sv
rtl/core/lnsa_divider.sv
rtl/core/lnsa_series.sv
rtl/core/natural_log_series_approx_core.sv
rtl/core/lnsa_checker.sv
tb/natural_log_series_approx_core_tb.sv
